// ===== src/lrtf_pkg.sv =====
package lrtf_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SLOT_W    = 4;
	localparam int ID_W      = 16;
	localparam int TIME_W    = 16;
	localparam int NOW_W     = 21;
	localparam int PC_W      = 5;

	localparam logic [NOW_W-1:0] NOW_MAX  = {NOW_W{1'b1}};
	localparam logic [PC_W-1:0]  PC_RESET = PC_W'(16);

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// running best candidate of one scan
	typedef struct packed {
		logic              found;
		logic [1:0]        nz_cnt;  // nonzero slots seen, saturates at 2
		logic [TIME_W-1:0] rem;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arr;
	} best_t;

endpackage

// ===== src/longest_remaining_time_first_scheduler.sv =====
// channel | direction | handshake          | word
// --------+-----------+--------------------+------------------------------------------
// in      | sink      | in_valid/in_stall  | req_type, slot, proc_id, arrival, burst
// out     | source    | out_valid/out_stall| ran_valid, ran_id, finished, turnaround,
//         |           |                    | all_done
// cfg     | sink      | cfg_we             | cfg_data (process_count)
//
// A tick is accepted, then scans n = min(process_count, SLOTS) slots of the
// slot table through its single registered read port into the shared compare
// unit, then updates. A load first writes the table, then scans and updates.
// in_stall is high from accept until the result is moved into the output
// register; the update cycle waits while a previous word sits stalled there.
// Reset clears control, the time counter and the per-slot valid bits at once.
module longest_remaining_time_first_scheduler #(
	parameter int SLOTS = lrtf_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrtf_pkg::PC_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [lrtf_pkg::SLOT_W-1:0]   slot,
	input  logic [lrtf_pkg::ID_W-1:0]     proc_id,
	input  logic [lrtf_pkg::TIME_W-1:0]   arrival,
	input  logic [lrtf_pkg::TIME_W-1:0]   burst,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ran_valid,
	output logic [lrtf_pkg::ID_W-1:0]     ran_id,
	output logic                          finished,
	output logic [lrtf_pkg::NOW_W-1:0]    turnaround,
	output logic                          all_done
);
	import lrtf_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [PC_W-1:0]   pc_q;
	logic [NOW_W-1:0]  now_q;
	logic [CNT_W-1:0]  idx_q;
	logic              rd_pend_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	// accepted word
	logic              req_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] arr_q;
	logic [TIME_W-1:0] burst_q;

	// output register
	logic              out_valid_q;
	logic              ran_valid_q;
	logic [ID_W-1:0]   ran_id_q;
	logic              finished_q;
	logic [NOW_W-1:0]  turnaround_q;
	logic              all_done_q;

	logic [CNT_W-1:0]  active_n;
	logic              in_acc;
	logic              out_free;
	logic              scan_re;
	logic              slot_ok;
	logic              tick;
	logic              done_upd;
	logic              last_run;
	logic              all_done_d;
	logic [NOW_W-1:0]  now_next;
	logic [TIME_W-1:0] rem_dec;

	logic [TIME_W-1:0] rd_rem;
	logic [ID_W-1:0]   rd_id;
	logic [TIME_W-1:0] rd_arr;
	best_t             best;
	logic [IDX_W-1:0]  best_idx;

	always_comb begin
		active_n   = (32'(pc_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(pc_q);
		in_acc     = in_valid && (state_q == ST_IDLE);
		out_free   = !out_valid_q || !out_stall;
		scan_re    = (state_q == ST_SCAN) && (idx_q < active_n);
		slot_ok    = 32'(slot_q) < SLOTS;
		tick       = (req_q == REQ_TICK);
		done_upd   = (state_q == ST_UPDATE) && out_free;
		now_next   = (now_q == NOW_MAX) ? now_q : now_q + NOW_W'(1);
		rem_dec    = best.rem + {TIME_W{1'b1}};    // remaining minus one
		last_run   = tick && best.found && (rem_dec == '0);
		// done if nothing left, or the only busy slot just ran out
		all_done_d = (best.nz_cnt == 2'd0) || ((best.nz_cnt == 2'd1) && last_run);
	end

	assign in_stall = (state_q != ST_IDLE);

	lrtf_table #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.we_all ((state_q == ST_LOAD) && slot_ok),
		.we_rem (done_upd && tick && best.found),
		.waddr  ((state_q == ST_LOAD) ? IDX_W'(slot_q) : best_idx),
		.wid    (id_q),
		.warr   (arr_q),
		.wrem   ((state_q == ST_LOAD) ? burst_q : rem_dec),
		.re     (scan_re),
		.raddr  (idx_q[IDX_W-1:0]),
		.rd_rem (rd_rem),
		.rd_id  (rd_id),
		.rd_arr (rd_arr)
	);

	lrtf_pick #(
		.IDX_W (IDX_W)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (in_acc),
		.elig_en  (tick),
		.now      (now_q),
		.cand_vld (rd_pend_s1),
		.cand_idx (rd_idx_s1),
		.cand_rem (rd_rem),
		.cand_id  (rd_id),
		.cand_arr (rd_arr),
		.best     (best),
		.best_idx (best_idx)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= PC_RESET;
			now_q      <= '0;
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_data;
			end
			rd_pend_s1 <= scan_re;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc) begin
						state_q <= (req_type == REQ_TICK) ? ST_SCAN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_re) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_UPDATE;  // last read is consumed this cycle
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						if (tick) begin
							now_q <= now_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IDX_W-1:0];
		if (in_acc) begin
			req_q   <= req_type;
			slot_q  <= slot;
			id_q    <= proc_id;
			arr_q   <= arrival;
			burst_q <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_upd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_upd) begin
			ran_valid_q  <= tick && best.found;
			ran_id_q     <= (tick && best.found) ? best.id : '0;
			finished_q   <= last_run;
			turnaround_q <= last_run ? (now_next - NOW_W'(best.arr)) : '0;
			all_done_q   <= all_done_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign ran_valid  = ran_valid_q;
	assign ran_id     = ran_id_q;
	assign finished   = finished_q;
	assign turnaround = turnaround_q;
	assign all_done   = all_done_q;

`ifndef ASSERT_OFF
	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> ran_valid)
		else $error("finished without a run");

	a_fin_tat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> turnaround != '0)
		else $error("zero turnaround on completion");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ran_valid |-> ran_id == '0 && !finished)
		else $error("idle word carries run data");

	a_best_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE && best.found |-> best.rem != '0 && best.nz_cnt != 2'd0)
		else $error("picked slot has no work");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != ST_IDLE)
		else $error("accepted word not processed");
`endif

endmodule

// ===== src/lrtf_table.sv =====
module lrtf_table #(
	parameter int SLOTS = lrtf_pkg::SLOTS_DEF,
	parameter int IDX_W = $clog2(SLOTS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we_all,
	input  logic                      we_rem,
	input  logic [IDX_W-1:0]          waddr,
	input  logic [lrtf_pkg::ID_W-1:0]   wid,
	input  logic [lrtf_pkg::TIME_W-1:0] warr,
	input  logic [lrtf_pkg::TIME_W-1:0] wrem,
	input  logic                      re,
	input  logic [IDX_W-1:0]          raddr,
	output logic [lrtf_pkg::TIME_W-1:0] rd_rem,
	output logic [lrtf_pkg::ID_W-1:0]   rd_id,
	output logic [lrtf_pkg::TIME_W-1:0] rd_arr
);
	import lrtf_pkg::*;

	logic [TIME_W-1:0] rem_mem [SLOTS];
	logic [ID_W-1:0]   id_mem  [SLOTS];
	logic [TIME_W-1:0] arr_mem [SLOTS];
	logic [SLOTS-1:0]  vld_q;
	logic              rd_vld_q;
	logic [TIME_W-1:0] rd_rem_q;
	logic [ID_W-1:0]   rd_id_q;
	logic [TIME_W-1:0] rd_arr_q;

	always_ff @(posedge clk) begin
		if (we_all || we_rem) begin
			rem_mem[waddr] <= wrem;
		end
		if (we_all) begin
			id_mem[waddr]  <= wid;
			arr_mem[waddr] <= warr;
		end
		if (re) begin
			rd_rem_q <= rem_mem[raddr];
			rd_id_q  <= id_mem[raddr];
			rd_arr_q <= arr_mem[raddr];
		end
	end

	// valid bits stand in for the all-zero reset of remaining time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we_all || we_rem) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rd_rem = rd_vld_q ? rd_rem_q : '0;
	assign rd_id  = rd_id_q;
	assign rd_arr = rd_arr_q;

endmodule

// ===== src/lrtf_pick.sv =====
module lrtf_pick #(
	parameter int IDX_W = $clog2(lrtf_pkg::SLOTS_DEF)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic                      elig_en,
	input  logic [lrtf_pkg::NOW_W-1:0]  now,
	input  logic                      cand_vld,
	input  logic [IDX_W-1:0]          cand_idx,
	input  logic [lrtf_pkg::TIME_W-1:0] cand_rem,
	input  logic [lrtf_pkg::ID_W-1:0]   cand_id,
	input  logic [lrtf_pkg::TIME_W-1:0] cand_arr,
	output lrtf_pkg::best_t           best,
	output logic [IDX_W-1:0]          best_idx
);
	import lrtf_pkg::*;

	best_t            best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             nz;
	logic             elig;
	logic             better;

	// single compare unit, one slot per cycle
	always_comb begin
		nz     = (cand_rem != '0);
		elig   = elig_en && nz && (NOW_W'(cand_arr) <= now);
		better = !best_q.found || (cand_rem > best_q.rem) ||
		         ((cand_rem == best_q.rem) && (cand_id < best_q.id));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clr) begin
			best_q.found  <= 1'b0;
			best_q.nz_cnt <= '0;
		end else if (cand_vld) begin
			if (nz && best_q.nz_cnt != 2'd2) begin
				best_q.nz_cnt <= best_q.nz_cnt + 2'd1;
			end
			if (elig && better) begin
				best_q.found <= 1'b1;
				best_q.rem   <= cand_rem;
				best_q.id    <= cand_id;
				best_q.arr   <= cand_arr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand_vld && elig && better) begin
			best_idx_q <= cand_idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule
